// ===== src/text_console_char_engine_assert.svh =====
// Assertion macros shared by the checker modules of the text console engine.
// Each macro samples on i_clk; the second and third also sit out reset.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH

// Implication without a reset guard, checked in the next cycle.
`define TCCE_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

// Same-cycle implication, disabled while in reset.
`define TCCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// Next-cycle implication, disabled while in reset.
`define TCCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

// ===== src/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Screen geometry, field widths, codes and shared types of the text console
// character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int ATTR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;

    // operations
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_LAST  = 8'h7F;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CODE_SPACE};

    // next cursor and side effects of one put-character word
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             write;
        logic             scroll;
    } t_cur_step;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

// ===== src/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int DEPTH = 2000,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tcce_cursor.sv =====
// ----------------------------------------------------------------------------
// tcce_cursor
// Next-cursor logic for one put-character word: backspace, CR/LF, printable
// advance, end-of-row wrap and scroll detection.
// ----------------------------------------------------------------------------
module tcce_cursor import tcce_pkg::*; (
    input  logic [COL_W-1:0]  i_col,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [CHAR_W-1:0] i_char_code,
    output t_cur_step         o_step
);

    logic [COL_W:0] col_n;
    logic [ROW_W:0] row_n;
    logic           printable;
    logic           scroll;

    always_comb begin
        printable = (i_char_code >= CODE_SPACE) && (i_char_code <= CODE_LAST);
        col_n     = {1'b0, i_col};
        row_n     = {1'b0, i_row};

        priority if (i_char_code == CODE_BS) begin
            if (i_col != '0) begin
                col_n = col_n - (COL_W+1)'(1);
            end
        end else if (i_char_code == CODE_CR || i_char_code == CODE_LF) begin
            col_n = '0;
            row_n = row_n + (ROW_W+1)'(1);
        end else if (printable) begin
            col_n = col_n + (COL_W+1)'(1);
        end else begin
            // drop other control codes and high bytes
            col_n = {1'b0, i_col};
        end

        // wrap at end of row
        if (col_n >= (COL_W+1)'(COLUMNS)) begin
            col_n = '0;
            row_n = row_n + (ROW_W+1)'(1);
        end

        scroll        = row_n >= (ROW_W+1)'(ROWS);
        o_step.col    = col_n[COL_W-1:0];
        o_step.row    = scroll ? ROW_W'(ROWS - 1) : row_n[ROW_W-1:0];
        o_step.write  = printable;
        o_step.scroll = scroll;
    end

endmodule

// ===== src/text_console_char_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine
// 80x25 text screen: cell store in one RAM, cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with func, char_code, colors, cell_index.
// Output channel: o_valid / i_stall with cursor_position and cell_data; one
// result word per input word, held in an output register until taken.
// Config: i_cfg_wr_en / i_cfg_wr_data write the blank attribute (reset 0x0F);
// write it only while the engine is idle.
// Steps per word, all set by the single screen RAM port pair:
//   put character, no scroll: result shows the next cycle
//   read cell: one RAM read in S_READ first; unused func: as put, no scroll
//   put character with scroll: copy rows up one cell a cycle, drain the last
//     copy, then blank the last row
//   clear screen: write the blank cell into every entry
// Reset: the cursor goes home and a clearing pass writes blank 0x0F20 cells
// into all COLUMNS*ROWS entries; o_stall stays high meanwhile.
// A new word is taken only while idle with the output register empty or
// being drained, so a stalled receiver holds the engine after one word.
// ----------------------------------------------------------------------------
module text_console_char_engine import tcce_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [ATTR_W-1:0]  i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [CHAR_W-1:0]  i_char_code,
    input  logic [COLOR_W-1:0] i_back_color,
    input  logic [COLOR_W-1:0] i_fore_color,
    input  logic [IDX_W-1:0]   i_cell_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [POS_W-1:0]   o_cursor_position,
    output logic [CELL_W-1:0]  o_cell_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_FILL,
        S_SCROLL,
        S_BLANK
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] BLANK_FROM = ADDR_W'(CELLS - COLUMNS);

    t_state             r_state;
    logic [ADDR_W-1:0]  r_cnt;
    logic               r_cp_valid;
    logic [ADDR_W-1:0]  r_cp_addr;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [ATTR_W-1:0]  r_blank_attr;
    logic               r_rd_ok;
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [CELL_W-1:0]  r_out_data;

    logic               in_acc;
    logic               out_take;
    logic               idx_ok;
    logic [CELL_W-1:0]  blank_cell;
    t_cur_step          cur_step;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    assign o_stall    = !(r_state == S_IDLE && (!r_out_valid || !i_stall));
    assign in_acc     = i_valid && !o_stall;
    assign out_take   = r_out_valid && !i_stall;
    assign idx_ok     = 32'(i_cell_index) < 32'(CELLS);
    assign blank_cell = {r_blank_attr, CODE_SPACE};

    tcce_cursor u_cursor (
        .i_col       (r_col),
        .i_row       (r_row),
        .i_char_code (i_char_code),
        .o_step      (cur_step)
    );

    tcce_ram #(
        .DEPTH (CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = blank_cell;
        ram_raddr = ADDR_W'(i_cell_index);
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
            end
            S_IDLE: begin
                if (in_acc && i_func == FUNC_PUT && cur_step.write) begin
                    ram_we    = 1'b1;
                    ram_waddr = cell_addr(r_row, r_col);
                    ram_wdata = {i_back_color, i_fore_color, i_char_code};
                end
            end
            S_READ: begin
                ram_we = 1'b0;
            end
            S_FILL: begin
                ram_we = 1'b1;
            end
            S_SCROLL, S_BLANK: begin
                // copy word read last cycle one row up; blank only when no copy is due
                ram_raddr = r_cnt + ADDR_W'(COLUMNS);
                if (r_cp_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cp_addr;
                    ram_wdata = ram_rdata;
                end else if (r_state == S_BLANK) begin
                    ram_we = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_cnt        <= '0;
            r_cp_valid   <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_blank_attr <= RESET_ATTR;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_blank_attr <= i_cfg_wr_data;
            end
            if (out_take) begin
                r_out_valid <= 1'b0;
            end
            r_cp_valid <= 1'b0;

            unique case (r_state)
                S_INIT: begin
                    if (r_cnt == LAST_CELL) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_func)
                            FUNC_PUT: begin
                                r_col <= cur_step.col;
                                r_row <= cur_step.row;
                                if (cur_step.scroll) begin
                                    r_cnt   <= '0;
                                    r_state <= S_SCROLL;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out_pos   <= POS_W'(cell_addr(cur_step.row, cur_step.col));
                                    r_out_data  <= '0;
                                end
                            end
                            FUNC_CLEAR: begin
                                r_col   <= '0;
                                r_row   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_FILL;
                            end
                            FUNC_READ: begin
                                r_rd_ok <= idx_ok;
                                r_state <= S_READ;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_out_pos   <= POS_W'(cell_addr(r_row, r_col));
                                r_out_data  <= '0;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_pos   <= POS_W'(cell_addr(r_row, r_col));
                    r_out_data  <= r_rd_ok ? ram_rdata : '0;
                    r_state     <= S_IDLE;
                end
                S_FILL: begin
                    if (r_cnt == LAST_CELL) begin
                        r_cnt       <= '0;
                        r_out_valid <= 1'b1;
                        r_out_pos   <= POS_W'(cell_addr(r_row, r_col));
                        r_out_data  <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + ADDR_W'(1);
                    end
                end
                S_SCROLL: begin
                    r_cp_valid <= 1'b1;
                    r_cp_addr  <= r_cnt;
                    if (r_cnt == COPY_LAST) begin
                        r_cnt   <= BLANK_FROM;
                        r_state <= S_BLANK;
                    end else begin
                        r_cnt <= r_cnt + ADDR_W'(1);
                    end
                end
                S_BLANK: begin
                    // hold the count while the last copy drains
                    if (!r_cp_valid) begin
                        if (r_cnt == LAST_CELL) begin
                            r_cnt       <= '0;
                            r_out_valid <= 1'b1;
                            r_out_pos   <= POS_W'(cell_addr(r_row, r_col));
                            r_out_data  <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + ADDR_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_cursor_position = r_out_pos;
    assign o_cell_data       = r_out_data;

endmodule

// ===== src/tcce_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the text console engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_char_engine_assert.svh"

module tcce_checker import tcce_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [FUNC_W-1:0]  i_func,
    input logic [IDX_W-1:0]   i_cell_index,
    input logic               o_valid,
    input logic               i_stall,
    input logic [POS_W-1:0]   o_cursor_position,
    input logic [CELL_W-1:0]  o_cell_data
);

    logic                    rd_acc;
    logic                    rd_far;
    logic [POS_W+CELL_W-1:0] out_word;
    logic                    r_far_1;
    logic                    r_far_2;

    assign rd_acc   = i_valid && !o_stall && i_func == FUNC_READ;
    assign rd_far   = rd_acc && 32'(i_cell_index) >= 32'(CELLS);
    assign out_word = {o_cursor_position, o_cell_data};

    // delay an out-of-range read through r_far_1 and r_far_2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far_1 <= 1'b0;
            r_far_2 <= 1'b0;
        end else begin
            r_far_1 <= rd_far;
            r_far_2 <= r_far_1;
        end
    end

    // reset starts the clearing pass: no word taken, no result shown
    `TCCE_ASSERT_NEXT_ALWAYS(a_reset_busy, !i_rst_n, o_stall && !o_valid)

    // a stalled result word holds
    `TCCE_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_word))

    // a read holds off the next word while it waits on the RAM
    `TCCE_ASSERT_NEXT(a_read_busy, rd_acc, o_stall)

    // a read beyond the screen returns zero, checked when it reaches r_far_2
    `TCCE_ASSERT_NOW(a_read_range, r_far_2, o_valid && o_cell_data == '0)

endmodule

bind text_console_char_engine tcce_checker u_checker (.*);
